// File: hdl/mhcs_pkg.sv
// Shared types, constants and helper functions of the heading and code span scanner.
package mhcs_pkg;

    // Line length limit: a line ends at its (LINE_BUFFER_BYTES-1)-th byte.
    localparam int unsigned LINE_BUFFER_BYTES = 80;
    localparam int unsigned POS_W             = 7;
    localparam int unsigned RUN_W             = 7;
    localparam int unsigned LEVEL_W           = 7;
    localparam logic [POS_W-1:0] LAST_POS     = POS_W'(LINE_BUFFER_BYTES - 2);
    localparam logic [POS_W-1:0] PREFIX_WS_MAX = POS_W'(3);
    localparam logic [RUN_W-1:0] RUN_MAX      = {RUN_W{1'b1}};

    // Character codes.
    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_HASH     = 8'd35;
    localparam logic [7:0] CH_DASH     = 8'd45;
    localparam logic [7:0] CH_BACKTICK = 8'd96;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_UPPER_A  = 8'd65;
    localparam logic [7:0] CH_UPPER_Z  = 8'd90;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Result kinds.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Line phase codes.
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_HASH   = 2'd1;
    localparam logic [1:0] PH_TEXT   = 2'd2;
    localparam logic [1:0] PH_OTHER  = 2'd3;

    localparam int unsigned TDATA_W = 24;

    typedef struct packed {
        logic               item_kind;
        logic [7:0]         text_byte;
        logic [7:0]         anchor_byte;
        logic [LEVEL_W-1:0] level;
    } result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE);
    endfunction

    // Open span length after a backtick run of length cur ends.
    function automatic logic [RUN_W-1:0] run_close(input logic [RUN_W-1:0] open_len,
                                                   input logic [RUN_W-1:0] cur_len);
        logic [RUN_W-1:0] res;
        res = open_len;
        if (cur_len != '0) begin
            if (open_len == '0) begin
                res = cur_len;
            end else if (open_len == cur_len) begin
                res = '0;
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] to_anchor(input logic [7:0] b);
        logic [7:0] a;
        a = b;
        if (b == CH_SPACE) begin
            a = CH_DASH;
        end else if ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
            a = b + CASE_OFFSET;
        end
        return a;
    endfunction

endpackage

// File: hdl/markdown_heading_code_span_scanner.sv
// An accepted byte waits in the input register until the output register is free; the
// state update between the two registers then loads its result, if any. Throughput: one
// byte per cycle while the result stream is not held off. A byte that gives no result
// still passes the tracking logic. Reset (aresetn low at a rising edge) empties both
// registers, closes any open code span, and returns the line tracking to the start of a line.
// Top level of the heading and code span scanner.
module markdown_heading_code_span_scanner (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input stream: one text byte per request.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] in_byte
    // Result stream: one heading text byte or end of heading per request.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mhcs_pkg::TDATA_W-1:0] m_tdata,   // [7:0] text_byte, [15:8] anchor_byte,
                                                    // [22:16] level, [23] zero
    output logic                         m_tuser    // [0] item_kind
);

    logic              hold_valid;
    logic [7:0]        hold_byte;
    logic              out_free;
    logic              step;
    logic              emit;
    mhcs_pkg::result_t result;

    // The held byte is processed whenever the result register can take a result;
    // the state is updated in the same cycle, so no result is ever lost.
    assign step = hold_valid && out_free;

    mhcs_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (step),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    mhcs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (hold_byte),
        .emit    (emit),
        .result  (result)
    );

    mhcs_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && emit),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hdl/mhcs_in_reg.sv
// Input register stage holding one accepted text byte.
module mhcs_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       hold_valid,
    output logic [7:0] hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // A byte is taken when the stage is empty or drains this cycle.
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

// File: hdl/mhcs_core.sv
// Line, heading and backtick tracking state with the per-byte decision logic.
module mhcs_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        in_byte,
    output logic              emit,
    output mhcs_pkg::result_t result
);

    logic [mhcs_pkg::RUN_W-1:0]   open_reg, open_next;
    logic [mhcs_pkg::RUN_W-1:0]   cur_reg, cur_next;
    logic [mhcs_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [mhcs_pkg::LEVEL_W-1:0] hash_reg, hash_next;

    logic                         last;
    logic                         drop;
    logic                         ws;
    logic [mhcs_pkg::RUN_W-1:0]   open_mid, cur_mid;
    logic [mhcs_pkg::LEVEL_W-1:0] hash_upd;

    assign ws   = mhcs_pkg::is_ws(in_byte);
    assign last = (in_byte == mhcs_pkg::CH_NEWLINE) || (pos_reg >= mhcs_pkg::LAST_POS);

    always_comb begin
        phase_next          = phase_reg;
        hash_upd            = hash_reg;
        emit                = 1'b0;
        drop                = 1'b0;
        result.item_kind    = mhcs_pkg::KIND_TEXT;
        result.text_byte    = in_byte;
        result.anchor_byte  = mhcs_pkg::to_anchor(in_byte);
        result.level        = hash_reg;
        unique case (phase_reg)
            mhcs_pkg::PH_PREFIX: begin
                if (open_reg != '0) begin
                    phase_next = mhcs_pkg::PH_OTHER;
                end else if (in_byte == mhcs_pkg::CH_HASH) begin
                    phase_next = mhcs_pkg::PH_HASH;
                    hash_upd   = mhcs_pkg::LEVEL_W'(1);
                end else if (!(ws && (pos_reg < mhcs_pkg::PREFIX_WS_MAX))) begin
                    phase_next = mhcs_pkg::PH_OTHER;
                end
            end
            mhcs_pkg::PH_HASH: begin
                if (in_byte == mhcs_pkg::CH_HASH) begin
                    if (hash_reg != {mhcs_pkg::LEVEL_W{1'b1}}) begin
                        hash_upd = hash_reg + 1'b1;
                    end
                end else if (ws && !last) begin
                    phase_next = mhcs_pkg::PH_TEXT;
                end else begin
                    phase_next = mhcs_pkg::PH_OTHER;
                end
            end
            mhcs_pkg::PH_TEXT: begin
                emit = 1'b1;
                if (last) begin
                    // The line's last byte closes the heading and is not tracked.
                    drop               = 1'b1;
                    result.item_kind   = mhcs_pkg::KIND_END;
                    result.text_byte   = '0;
                    result.anchor_byte = '0;
                end
            end
            default: begin
                phase_next = mhcs_pkg::PH_OTHER;
            end
        endcase
    end

    // Backtick runs: count, then close at any other byte and at a line end.
    always_comb begin
        open_mid = open_reg;
        cur_mid  = cur_reg;
        if (!drop) begin
            if (in_byte == mhcs_pkg::CH_BACKTICK) begin
                if (cur_reg != mhcs_pkg::RUN_MAX) begin
                    cur_mid = cur_reg + 1'b1;
                end
            end else begin
                open_mid = mhcs_pkg::run_close(open_reg, cur_reg);
                cur_mid  = '0;
            end
        end
        if (last) begin
            open_next  = mhcs_pkg::run_close(open_mid, cur_mid);
            cur_next   = '0;
            pos_next   = '0;
            hash_next  = '0;
        end else begin
            open_next  = open_mid;
            cur_next   = cur_mid;
            pos_next   = pos_reg + 1'b1;
            hash_next  = hash_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= '0;
            cur_reg   <= '0;
            pos_reg   <= '0;
            phase_reg <= mhcs_pkg::PH_PREFIX;
            hash_reg  <= '0;
        end else if (step) begin
            open_reg  <= open_next;
            cur_reg   <= cur_next;
            pos_reg   <= pos_next;
            phase_reg <= last ? mhcs_pkg::PH_PREFIX : phase_next;
            hash_reg  <= hash_next;
        end
    end

endmodule

// File: hdl/mhcs_out_reg.sv
// Result register driving the master side of the result stream.
module mhcs_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  mhcs_pkg::result_t             result,
    output logic                          free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mhcs_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);

    logic              valid_reg;
    logic              valid_next;
    mhcs_pkg::result_t res_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : ((valid_reg && m_tready) ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.item_kind;
    assign m_tdata  = {1'b0, res_reg.level, res_reg.anchor_byte, res_reg.text_byte};

endmodule

// File: test/tb.sv
// Self-checking testbench for the markdown heading and code span scanner.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhcs_pkg::*;

    // One byte of stimulus. A row with a typed result carries its expectation
    // in the table itself. Every other row is checked against the scanner model below.
    typedef struct {
        logic [7:0] b;
        bit         typed;
        result_t    want;
    } stim_row_t;

    localparam int DIR_ROWS    = 32;
    localparam int RANDOM_BYTES = 320;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 20;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;

    markdown_heading_code_span_scanner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Directed bytes. The rows that produce heading items whose values are
    // obvious carry them. The span lines and the rejected lines rely on the model.
    stim_row_t dir_tab [DIR_ROWS] = '{
        // A level-1 heading with a tab separator. Its text holds a zero byte,
        // a capital, a space and 0xFF, and the newline gives the end item.
        '{CH_HASH,    1'b0, '0},
        '{CH_TAB,     1'b0, '0},
        '{8'h00,      1'b1, '{KIND_TEXT, 8'h00, 8'h00, 7'd1}},
        '{8'h41,      1'b1, '{KIND_TEXT, 8'h41, 8'h61, 7'd1}},
        '{CH_SPACE,   1'b1, '{KIND_TEXT, CH_SPACE, CH_DASH, 7'd1}},
        '{8'hFF,      1'b1, '{KIND_TEXT, 8'hFF, 8'hFF, 7'd1}},
        '{CH_NEWLINE, 1'b1, '{KIND_END, 8'h00, 8'h00, 7'd1}},
        // Three blanks of indent and then a level-2 heading whose text is empty.
        '{CH_SPACE,   1'b0, '0},
        '{CH_SPACE,   1'b0, '0},
        '{CH_SPACE,   1'b0, '0},
        '{CH_HASH,    1'b0, '0},
        '{CH_HASH,    1'b0, '0},
        '{CH_SPACE,   1'b0, '0},
        '{CH_NEWLINE, 1'b1, '{KIND_END, 8'h00, 8'h00, 7'd2}},
        // A fourth blank in the indent rejects the line.
        '{CH_TAB,     1'b0, '0},
        '{CH_TAB,     1'b0, '0},
        '{CH_TAB,     1'b0, '0},
        '{CH_TAB,     1'b0, '0},
        '{CH_HASH,    1'b0, '0},
        '{CH_SPACE,   1'b0, '0},
        '{8'h61,      1'b0, '0},
        '{CH_NEWLINE, 1'b0, '0},
        // One backtick opens a span. The heading in the next line is ignored,
        // and another single backtick closes the span.
        '{CH_BACKTICK, 1'b0, '0},
        '{CH_NEWLINE,  1'b0, '0},
        '{CH_HASH,     1'b0, '0},
        '{CH_SPACE,    1'b0, '0},
        '{8'h78,       1'b0, '0},
        '{CH_NEWLINE,  1'b0, '0},
        '{CH_BACKTICK, 1'b0, '0},
        '{CH_NEWLINE,  1'b0, '0},
        // The only whitespace after the hash is the newline, so there is no heading.
        '{CH_HASH,     1'b0, '0},
        '{CH_NEWLINE,  1'b0, '0}
    };

    stim_row_t   feed_q[$];
    result_t     heading_q[$];
    stim_row_t   cur_row;
    int unsigned bad_count = 0;
    int          press_at  = -1;
    bit          hold_req  = 1'b0;
    int          span_guess = 0;

    // Model of the scanner's state.
    logic [RUN_W-1:0]   span_len;
    logic [RUN_W-1:0]   run_len;
    logic [POS_W-1:0]   col;
    logic [1:0]         phase;
    logic [LEVEL_W-1:0] hashes;

    task automatic report_bad(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch in %s: got %0h, want %0h at %0t", what, got, want, $time);
        bad_count++;
    endtask

    // When a backtick run ends, it either opens a span or closes one of the same length.
    task automatic finish_run();
        if (run_len != '0) begin
            if (span_len == '0) begin
                span_len = run_len;
            end else if (span_len == run_len) begin
                span_len = '0;
            end
            run_len = '0;
        end
    endtask

    // Advance the model by one byte. The task reports whether the byte produces
    // a heading item, and which one.
    task automatic predict_heading(input logic [7:0] b, output bit emit, output result_t res);
        bit blank;
        bit last_b;
        bit drop;
        blank  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        last_b = (b == CH_NEWLINE) || (int'(col) + 2 >= LINE_BUFFER_BYTES);
        drop   = 1'b0;
        emit   = 1'b0;
        res    = '0;
        case (phase)
            PH_PREFIX: begin
                if (span_len != '0) begin
                    phase = PH_OTHER;
                end else if (b == CH_HASH) begin
                    phase  = PH_HASH;
                    hashes = LEVEL_W'(1);
                end else if (!(blank && (col < PREFIX_WS_MAX))) begin
                    phase = PH_OTHER;
                end
            end
            PH_HASH: begin
                if (b == CH_HASH) begin
                    if (hashes < RUN_MAX) begin
                        hashes = hashes + 1'b1;
                    end
                end else if (blank && !last_b) begin
                    phase = PH_TEXT;
                end else begin
                    phase = PH_OTHER;
                end
            end
            PH_TEXT: begin
                emit      = 1'b1;
                res.level = hashes;
                if (last_b) begin
                    // The last byte of the line closes the heading and is consumed.
                    res.item_kind = KIND_END;
                    drop          = 1'b1;
                end else begin
                    res.item_kind   = KIND_TEXT;
                    res.text_byte   = b;
                    res.anchor_byte = b;
                    if (b == CH_SPACE) begin
                        res.anchor_byte = CH_DASH;
                    end else if ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
                        res.anchor_byte = b + CASE_OFFSET;
                    end
                end
            end
            default: begin
                phase = PH_OTHER;
            end
        endcase
        if (!drop) begin
            if (b == CH_BACKTICK) begin
                if (run_len < RUN_MAX) begin
                    run_len = run_len + 1'b1;
                end
            end else begin
                finish_run();
            end
        end
        if (last_b) begin
            finish_run();
            col    = '0;
            phase  = PH_PREFIX;
            hashes = '0;
        end else begin
            col = col + 1'b1;
        end
    endtask

    task automatic push_byte(logic [7:0] b);
        stim_row_t row;
        row.b     = b;
        row.typed = 1'b0;
        row.want  = '0;
        feed_q.push_back(row);
    endtask

    // Returns a whitespace byte that does not end the line, usually a space.
    function automatic logic [7:0] pick_blank();
        logic [7:0] b;
        b = 8'($urandom_range(CH_TAB, CH_CR));
        if ((b == CH_NEWLINE) || ($urandom_range(0, 1) == 0)) begin
            b = CH_SPACE;
        end
        return b;
    endfunction

    // Returns a text byte. It is never a newline or a backtick, so runs and line
    // ends happen only where the generator places them.
    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0, 1, 2: b = 8'($urandom_range(8'h61, 8'h7A));
            3:       b = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            4:       b = CH_SPACE;
            5:       b = 8'($urandom_range(8'h30, 8'h39));
            default: begin
                b = 8'($urandom_range(0, 255));
                if ((b == CH_NEWLINE) || (b == CH_BACKTICK)) begin
                    b = CH_HASH;
                end
            end
        endcase
        return b;
    endfunction

    // A well-formed heading line. Balanced code spans may appear in its text.
    // If cut is set, the text is long enough that the line hits the length limit.
    task automatic put_heading(int pre, int nhash, int ntext, bit cut);
        int left;
        repeat (pre) push_byte(pick_blank());
        repeat (nhash) push_byte(CH_HASH);
        push_byte(pick_blank());
        left = cut ? 90 : ntext;
        while (left > 0) begin
            if ($urandom_range(0, 11) == 0) begin
                push_byte(CH_BACKTICK);
                push_byte(pick_text());
                push_byte(CH_BACKTICK);
                left -= 3;
            end else begin
                push_byte(pick_text());
                left--;
            end
        end
        push_byte(CH_NEWLINE);
    endtask

    // A line with one bare backtick run. It opens a span of 1 to 3 backticks,
    // or it closes the span that the previous such line opened.
    task automatic put_tick_line();
        int len;
        if (span_guess == 0) begin
            len        = $urandom_range(1, 3);
            span_guess = len;
        end else begin
            len        = span_guess;
            span_guess = 0;
        end
        repeat ($urandom_range(0, 3)) push_byte(pick_text());
        repeat (len) push_byte(CH_BACKTICK);
        repeat ($urandom_range(0, 3)) push_byte(pick_text());
        push_byte(CH_NEWLINE);
    endtask

    // Lines that look almost like headings but fail at some point.
    task automatic put_broken();
        case ($urandom_range(0, 4))
            0: begin
                push_byte(CH_HASH);
                push_byte(8'($urandom_range(8'h61, 8'h7A)));
                repeat ($urandom_range(0, 5)) push_byte(pick_text());
            end
            1: repeat ($urandom_range(1, 4)) push_byte(CH_HASH);
            2: begin
                repeat (4) push_byte(pick_blank());
                push_byte(CH_HASH);
                push_byte(pick_blank());
                repeat ($urandom_range(1, 5)) push_byte(pick_text());
            end
            3: repeat (LINE_BUFFER_BYTES - 1) push_byte(CH_HASH);
            default: begin
                // The separator blank falls on the last byte of the line.
                repeat (LINE_BUFFER_BYTES - 2) push_byte(CH_HASH);
                push_byte(pick_blank());
            end
        endcase
        push_byte(CH_NEWLINE);
    endtask

    // Stimulus generation, reset, the sending side and the end of the run.
    initial begin
        int pre;
        int nhash;
        int pick;
        int gap;
        int tx_quiet;
        int target;

        for (int i = 0; i < DIR_ROWS; i++) begin
            feed_q.push_back(dir_tab[i]);
        end
        // A long level-2 heading during which the receiver holds off. This fills
        // the scanner and stalls its input. The line also runs into the length limit.
        press_at = feed_q.size();
        put_heading(0, 2, 0, 1'b1);

        target = feed_q.size() + RANDOM_BYTES;
        while (feed_q.size() < target) begin
            pick = $urandom_range(0, 15);
            if (pick <= 6) begin
                pre   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 3);
                nhash = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 77 - pre)
                                                    : $urandom_range(1, 6);
                if ($urandom_range(0, 19) == 0) begin
                    pre   = 0;
                    nhash = 77;
                end
                put_heading(pre, nhash, $urandom_range(0, 12), $urandom_range(0, 7) == 0);
            end else if (pick <= 8) begin
                put_tick_line();
            end else if (pick <= 10) begin
                repeat ($urandom_range(0, 20)) push_byte(8'($urandom_range(0, 255)));
                push_byte(CH_NEWLINE);
            end else if (pick == 11) begin
                repeat ($urandom_range(79, 100)) push_byte(pick_text());
                push_byte(CH_NEWLINE);
            end else begin
                put_broken();
            end
        end

        span_len = '0;
        run_len  = '0;
        col      = '0;
        phase    = PH_PREFIX;
        hashes   = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender. Each request may first wait, with the valid signal low. During quiet
        // stretches it does not wait at all. The valid signal stays high from
        // one request to the next when there is no wait.
        tx_quiet = 0;
        for (int i = 0; i < feed_q.size(); i++) begin
            if (i == press_at) begin
                hold_req = 1'b1;
                tx_quiet = 120;
            end
            if (tx_quiet > 0) begin
                gap = 0;
                tx_quiet--;
            end else begin
                if ($urandom_range(0, 39) == 0) begin
                    tx_quiet = $urandom_range(20, 60);
                end
                gap = $urandom_range(0, 8);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= feed_q[i].b;
            cur_row  <= feed_q[i];
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
        s_tvalid <= 1'b0;

        // Wait for every expected heading item, then keep watching the output so
        // that an unexpected late item would still be seen.
        while (heading_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bad_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Receiver. Before each request it may stall, with
    // quiet stretches of no stall. When asked to, it holds off for a long time.
    initial begin
        int stall;
        int rx_quiet;
        rx_quiet = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            if (rx_quiet > 0) begin
                stall = 0;
                rx_quiet--;
            end else begin
                if ($urandom_range(0, 29) == 0) begin
                    rx_quiet = $urandom_range(10, 40);
                end
                stall = $urandom_range(0, 8);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // At each edge, every accepted result is checked against the oldest
    // expectation, and every accepted input byte is run through the model.
    always @(posedge aclk) begin : check_and_predict
        result_t want_r;
        result_t pred;
        bit      emit;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (heading_q.size() == 0) begin
                    report_bad("unexpected result", {m_tuser, m_tdata}, 0);
                end else begin
                    want_r = heading_q.pop_front();
                    if (m_tuser !== want_r.item_kind) begin
                        report_bad("item_kind", m_tuser, want_r.item_kind);
                    end
                    if (m_tdata[7:0] !== want_r.text_byte) begin
                        report_bad("text_byte", m_tdata[7:0], want_r.text_byte);
                    end
                    if (m_tdata[15:8] !== want_r.anchor_byte) begin
                        report_bad("anchor_byte", m_tdata[15:8], want_r.anchor_byte);
                    end
                    if (m_tdata[22:16] !== want_r.level) begin
                        report_bad("level", m_tdata[22:16], want_r.level);
                    end
                    if (m_tdata[23] !== 1'b0) begin
                        report_bad("pad bit", m_tdata[23], 0);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_heading(cur_row.b, emit, pred);
                if (cur_row.typed) begin
                    heading_q.push_back(cur_row.want);
                end else if (emit) begin
                    heading_q.push_back(pred);
                end
            end
        end
    end

    // Run limit: far longer than the slowest correct run, including the long hold-off.
    initial begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

endmodule
